/* hw/rtl/pomppt_pkg.sv */
// shared types and constants of the perturb-and-observe tracker
package pomppt_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_STEP_SIZE      = 3'd0;
   localparam logic [2:0] REG_INITIAL_DUTY   = 3'd1;
   localparam logic [2:0] REG_DUTY_MAX       = 3'd2;
   localparam logic [2:0] REG_DUTY_MIN       = 3'd3;
   localparam logic [2:0] REG_DROP_THRESHOLD = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register values after reset
   localparam logic [15:0] STEP_SIZE_RST      = 16'd328;
   localparam logic [15:0] INITIAL_DUTY_RST   = 16'd32768;
   localparam logic [15:0] DUTY_MAX_RST       = 16'd51118;
   localparam logic [15:0] DUTY_MIN_RST       = 16'd33423;
   localparam logic [31:0] DROP_THRESHOLD_RST = 32'd131072;

   // signed working width of the duty arithmetic
   localparam int DUTY_CALC_W = 20;

   typedef struct packed {
      logic [15:0] voltage;
      logic [15:0] current;
      logic        restart;
   } req_type;

   typedef struct packed {
      logic [15:0] duty_command;
      logic [31:0] peak_power;
      logic [15:0] peak_duty;
      logic        direction;
   } rsp_type;

endpackage

/* hw/rtl/pomppt_req_if.sv */
// sample channel interface: valid, ready and one sample
interface pomppt_req_if;
   logic                 valid;
   logic                 ready;
   pomppt_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pomppt_rsp_if.sv */
// result channel interface: valid, ready and one result
interface pomppt_rsp_if;
   logic                 valid;
   logic                 ready;
   pomppt_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/perturb_observe_mppt_core.sv */
// perturb-and-observe maximum power point tracker, top level
//
// req_ch carries one voltage and current sample (Q8.8) and a restart flag per
// transfer; rsp_ch returns one result per sample: the new duty (Q0.16), the
// peak power since restart (Q16.16), the duty at that peak and the direction.
// The csr_ port writes the five tuning registers; the user must do so only
// while the block idles; the block itself does not enforce this.
// Three stages: sample register, power product register, result register.
// Samples pass through them in order; one sample is taken every cycle while
// the receiver keeps up. The 16x16 product sits alone in the second stage;
// the tracker state updates as a result is loaded into the output register.
// Reset clears the pipeline, loads the register defaults, sets the direction
// to increasing and clears the duty, previous power and peak tracker.
// When the receiver stalls, the result holds and earlier stages keep filling
// until each holds a sample; then req_ch.ready drops.
module perturb_observe_mppt_core (
   input  logic                                clock,
   input  logic                                reset,
   pomppt_req_if.sink                          req_ch,
   pomppt_rsp_if.source                        rsp_ch,
   input  logic                                csr_we,
   input  logic [pomppt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pomppt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int W = pomppt_pkg::DUTY_CALC_W;

   // configuration registers
   logic [15:0] step_size_ff;
   logic [15:0] initial_duty_ff;
   logic [15:0] duty_max_ff;
   logic [15:0] duty_min_ff;
   logic [31:0] drop_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff      <= pomppt_pkg::STEP_SIZE_RST;
         initial_duty_ff   <= pomppt_pkg::INITIAL_DUTY_RST;
         duty_max_ff       <= pomppt_pkg::DUTY_MAX_RST;
         duty_min_ff       <= pomppt_pkg::DUTY_MIN_RST;
         drop_threshold_ff <= pomppt_pkg::DROP_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pomppt_pkg::REG_STEP_SIZE:      step_size_ff      <= csr_wdata[15:0];
            pomppt_pkg::REG_INITIAL_DUTY:   initial_duty_ff   <= csr_wdata[15:0];
            pomppt_pkg::REG_DUTY_MAX:       duty_max_ff       <= csr_wdata[15:0];
            pomppt_pkg::REG_DUTY_MIN:       duty_min_ff       <= csr_wdata[15:0];
            pomppt_pkg::REG_DROP_THRESHOLD: drop_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline flow: a stage loads when empty or when it passes its item on
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_load, s2_load, s3_load;

   assign s3_load      = !rsp_valid_ff || rsp_ch.ready;
   assign s2_load      = !s2_valid_ff || s3_load;
   assign s1_load      = !s1_valid_ff || s2_load;
   assign req_ch.ready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff  <= req_ch.valid;
         if (s2_load) s2_valid_ff  <= s1_valid_ff;
         if (s3_load) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // sample register
   pomppt_pkg::req_type s1_data_ff;

   always_ff @(posedge clock) begin
      if (s1_load) s1_data_ff <= req_ch.data;
   end

   // power product register
   logic [31:0] s2_power_ff;
   logic        s2_restart_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_power_ff   <= 32'(s1_data_ff.voltage * s1_data_ff.current);
         s2_restart_ff <= s1_data_ff.restart;
      end
   end

   // tracker state
   logic [31:0] prev_power_ff, prev_power_in;
   logic        going_up_ff, going_up_in;
   logic [15:0] duty_value_ff, duty_value_in;
   logic [31:0] best_power_ff, best_power_in;
   logic [15:0] best_duty_ff, best_duty_in;

   // restart view of duty and peak tracker
   logic [15:0] cur_duty;
   logic [31:0] base_power;
   logic [15:0] base_duty;
   logic signed [33:0] drop;
   logic signed [W-1:0] step_s, triple_s, duty_s, d_raw, d_hi, d_lo;

   always_comb begin
      cur_duty   = s2_restart_ff ? initial_duty_ff : duty_value_ff;
      base_power = s2_restart_ff ? 32'd0 : best_power_ff;
      base_duty  = s2_restart_ff ? 16'd0 : best_duty_ff;

      // direction flips when power fell by at least the threshold
      drop = signed'({2'b00, prev_power_ff}) - signed'({2'b00, s2_power_ff});
      going_up_in   = going_up_ff ^ (drop >= signed'({2'b00, drop_threshold_ff}));
      prev_power_in = s2_power_ff;

      // peak tracker keeps the duty in effect before this update
      if (s2_power_ff > base_power) begin
         best_power_in = s2_power_ff;
         best_duty_in  = cur_duty;
      end else begin
         best_power_in = base_power;
         best_duty_in  = base_duty;
      end

      // perturb, pull back inside the limits, then saturate
      step_s   = signed'(W'(step_size_ff));
      triple_s = signed'(W'({step_size_ff, 1'b0})) + step_s;
      duty_s   = signed'(W'(cur_duty));
      d_raw    = going_up_in ? (duty_s + step_s) : (duty_s - step_s);
      d_hi     = (d_raw > signed'(W'(duty_max_ff)))
                 ? (signed'(W'(duty_max_ff)) - triple_s) : d_raw;
      d_lo     = (d_hi < signed'(W'(duty_min_ff)))
                 ? (signed'(W'(duty_min_ff)) + triple_s) : d_hi;
      priority if (d_lo < 0)
         duty_value_in = 16'd0;
      else if (d_lo > signed'(W'(17'h0FFFF)))
         duty_value_in = 16'hFFFF;
      else
         duty_value_in = d_lo[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_power_ff <= 32'd0;
         going_up_ff   <= 1'b1;
         duty_value_ff <= 16'd0;
         best_power_ff <= 32'd0;
         best_duty_ff  <= 16'd0;
      end else if (s3_load && s2_valid_ff) begin
         prev_power_ff <= prev_power_in;
         going_up_ff   <= going_up_in;
         duty_value_ff <= duty_value_in;
         best_power_ff <= best_power_in;
         best_duty_ff  <= best_duty_in;
      end
   end

   // result register
   pomppt_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (s3_load) begin
         rsp_data_ff.duty_command <= duty_value_in;
         rsp_data_ff.peak_power   <= best_power_in;
         rsp_data_ff.peak_duty    <= best_duty_in;
         rsp_data_ff.direction    <= going_up_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule
